// ===== rtl/cscp_pkg.sv =====
`timescale 1ns / 1ps
package cscp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CW = 19;            // coordinate width
    localparam int KW = 17;            // knot field width
    localparam int TW = 16;            // tension width
    localparam logic [TW-1:0] TENSION_RST = 16'd13107;
    localparam int DW = 40;            // divider operand width

    typedef logic signed [CW-1:0] t_coord;

    function automatic t_coord sat19(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        hi = DW'(262143);
        lo = -DW'(262144);
        if (v > hi) return t_coord'(hi);
        if (v < lo) return t_coord'(lo);
        return t_coord'(v);
    endfunction
endpackage

// ===== rtl/cscp_div.sv =====
`timescale 1ns / 1ps
// signed restoring divider, quotient truncated toward zero, zero on zero divisor
module cscp_div
    import cscp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quo
);
    localparam int CNTW = $clog2(DW + 1);
    logic [DW-1:0]   r_q, n_q;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_den;
    logic            r_neg, r_busy, r_zero;
    logic [CNTW-1:0] r_cnt;
    logic [DW:0]     trial;
    logic [DW-1:0]   an, ad;

    assign an = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign ad = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    always_comb begin
        trial = {r_rem, r_q[DW-1]} - {1'b0, r_den};
        if (!trial[DW]) begin
            n_rem = trial[DW-1:0];
            n_q   = {r_q[DW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[DW-2:0], r_q[DW-1]};
            n_q   = {r_q[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= an;
                r_rem  <= '0;
                r_den  <= ad;
                r_zero <= (i_den == '0);
                r_neg  <= i_num[DW-1] ^ i_den[DW-1];
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_quo = r_zero ? '0 : (r_neg ? -$signed(r_q) : $signed(r_q));
endmodule

// ===== rtl/curve_segment_control_points.sv =====
`timescale 1ns / 1ps
// a knot that completes a window runs S_TAN, then S_FIXB and S_FIXC divide to clip the
// control points and, where they cross, S_MIDC and S_MIDB move both to their midpoint (up
// to four divisions per segment) before S_OUT loads the output register; a last knot runs
// a second segment the same way once the first is in the output register; the input takes
// one knot at a time, and a full output register holds the sequencer and the input
// reset (synchronous, active low): window and knot count cleared, tension 0.2
module curve_segment_control_points
    import cscp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // knot_x, knot_y
    input  logic         s_axis_tlast,   // last_knot
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // start_x/y, ctrl1_x/y, ctrl2_x/y, end_x/y
    output logic         m_axis_tlast    // last_segment
);
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS_DEF;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_TAN  = 7'b0000010, S_FIXB = 7'b0000100,
        S_FIXC = 7'b0001000, S_MIDC = 7'b0010000, S_MIDB = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st;
    logic [TW-1:0] r_tension;
    t_coord r_wx [3];
    t_coord r_wy [3];
    logic [1:0] r_seen;
    t_coord r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;
    t_coord r_kx, r_ky;
    logic r_last, r_second;
    t_coord r_b2x, r_b2y, r_c2x, r_c2y, r_mid;
    logic [1:0] r_tstep;
    logic r_wait;

    logic signed [DW-1:0] d_num, d_den;
    logic r_dstart, n_dstart, d_done;
    logic signed [DW-1:0] d_quo;

    cscp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quo(d_quo)
    );

    // shared tangent multiplier
    logic signed [DW-1:0] t_diff, t_prod, t_val;
    always_comb begin
        case (r_tstep)
            2'd0:    t_diff = DW'(r_cx) - DW'(r_ax);
            2'd1:    t_diff = DW'(r_cy) - DW'(r_ay);
            2'd2:    t_diff = DW'(r_bx) - DW'(r_dx);
            default: t_diff = DW'(r_by) - DW'(r_dy);
        endcase
        t_prod = t_diff * $signed({1'b0, r_tension}) + DW'(32768);
        t_val  = t_prod >>> 16;
    end

    function automatic t_coord clampu(input logic signed [DW-1:0] v);
        if (v < 0) return '0;
        if (v > ONE) return t_coord'(ONE);
        return t_coord'(v);
    endfunction

    // division setup per state, one shared product for the numerator
    logic signed [DW-1:0] mid_sum;
    logic signed [20:0] m_a, m_b;
    logic signed [41:0] m_p;
    assign mid_sum = (DW'(r_b2x) + DW'(r_c2x)) >>> 1;
    always_comb begin
        case (r_st)
            S_FIXB: begin
                m_a   = 21'(r_cx) - 21'(r_bx);
                m_b   = 21'(r_b2y) - 21'(r_cy);
                d_den = DW'(r_b2x) - DW'(r_bx);
            end
            S_FIXC: begin
                m_a   = 21'(r_cx) - 21'(r_bx);
                m_b   = 21'(r_c2y) - 21'(r_by);
                d_den = DW'(r_cx) - DW'(r_c2x);
            end
            S_MIDC: begin
                m_a   = 21'(r_mid) - 21'(r_cx);
                m_b   = 21'(r_cy) - 21'(r_c2y);
                d_den = DW'(r_cx) - DW'(r_c2x);
            end
            default: begin
                m_a   = 21'(r_mid) - 21'(r_bx);
                m_b   = 21'(r_by) - 21'(r_b2y);
                d_den = DW'(r_bx) - DW'(r_b2x);
            end
        endcase
        m_p   = m_a * m_b;
        d_num = DW'(m_p);
    end

    always_comb begin
        case (r_st)
            S_FIXB:         n_dstart = !r_wait && (r_b2x > r_cx);
            S_FIXC:         n_dstart = !r_wait && (r_c2x < r_bx);
            S_MIDC, S_MIDB: n_dstart = !r_wait;
            default:        n_dstart = 1'b0;
        endcase
    end

    logic m_busy;
    assign m_busy = m_axis_tvalid && !m_axis_tready;
    assign s_axis_tready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_tension <= TENSION_RST;
            r_seen <= '0;
            for (int i = 0; i < 3; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
            m_axis_tvalid <= 1'b0;
            r_dstart <= 1'b0;
            r_wait <= 1'b0;
            r_tstep <= '0;
        end else begin
            r_dstart <= n_dstart;
            if (i_cfg_we) r_tension <= i_cfg_wdata;
            // a transfer in S_OUT is followed by the next segment instead
            if (m_axis_tvalid && m_axis_tready && r_st != S_OUT) m_axis_tvalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kx <= t_coord'(s_axis_tdata[16:0]);
                        r_ky <= t_coord'(s_axis_tdata[33:17]);
                        r_last <= s_axis_tlast;
                        r_second <= 1'b0;
                        r_ax <= (r_seen == 2'd2) ? t_coord'(2 * r_wx[1] - r_wx[2]) : r_wx[0];
                        r_ay <= (r_seen == 2'd2) ? t_coord'(2 * r_wy[1] - r_wy[2]) : r_wy[0];
                        r_bx <= r_wx[1]; r_by <= r_wy[1];
                        r_cx <= r_wx[2]; r_cy <= r_wy[2];
                        r_dx <= t_coord'(s_axis_tdata[16:0]);
                        r_dy <= t_coord'(s_axis_tdata[33:17]);
                        r_wx[0] <= r_wx[1]; r_wy[0] <= r_wy[1];
                        r_wx[1] <= r_wx[2]; r_wy[1] <= r_wy[2];
                        r_wx[2] <= t_coord'(s_axis_tdata[16:0]);
                        r_wy[2] <= t_coord'(s_axis_tdata[33:17]);
                        if (s_axis_tlast) r_seen <= '0;
                        else if (r_seen != 2'd3) r_seen <= r_seen + 1'b1;
                        r_tstep <= '0;
                        if (r_seen >= 2'd2) r_st <= S_TAN;
                    end
                end
                S_TAN: begin
                    r_tstep <= r_tstep + 1'b1;
                    case (r_tstep)
                        2'd0: r_b2x <= sat19(DW'(r_bx) + t_val);
                        2'd1: r_b2y <= clampu(DW'(r_by) + t_val);
                        2'd2: r_c2x <= sat19(DW'(r_cx) + t_val);
                        default: begin
                            r_c2y <= clampu(DW'(r_cy) + t_val);
                            r_st <= S_FIXB;
                            r_wait <= 1'b0;
                        end
                    endcase
                end
                S_FIXB: begin
                    if (!r_wait) begin
                        if (r_b2x > r_cx) r_wait <= 1'b1;
                        else r_st <= S_FIXC;
                    end else if (d_done) begin
                        r_b2y <= sat19(DW'(r_cy) + d_quo);
                        r_b2x <= r_cx;
                        r_wait <= 1'b0;
                        r_st <= S_FIXC;
                    end
                end
                S_FIXC: begin
                    if (!r_wait) begin
                        if (r_c2x < r_bx) begin
                            r_wait <= 1'b1;
                        end else begin
                            r_mid <= t_coord'(mid_sum);
                            r_st <= (r_c2x < r_b2x) ? S_MIDC : S_OUT;
                        end
                    end else if (d_done) begin
                        r_c2y <= sat19(DW'(r_by) + d_quo);
                        r_c2x <= r_bx;
                        r_wait <= 1'b0;
                    end
                end
                S_MIDC: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (d_done) begin
                        r_c2y <= sat19(DW'(r_cy) + d_quo);
                        r_wait <= 1'b0;
                        r_st <= S_MIDB;
                    end
                end
                S_MIDB: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (d_done) begin
                        r_b2y <= sat19(DW'(r_by) + d_quo);
                        r_b2x <= r_mid;
                        r_c2x <= r_mid;
                        r_wait <= 1'b0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_busy) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= {r_cy, r_cx, r_c2y, r_c2x,
                                         r_b2y, r_b2x, r_by, r_bx};
                        m_axis_tlast <= r_second;
                        if (r_last && !r_second) begin
                            // final segment with mirrored phantom end knot
                            r_second <= 1'b1;
                            r_ax <= r_bx; r_ay <= r_by;
                            r_bx <= r_cx; r_by <= r_cy;
                            r_cx <= r_kx; r_cy <= r_ky;
                            r_dx <= t_coord'(2 * r_kx - r_cx);
                            r_dy <= t_coord'(2 * r_ky - r_cy);
                            r_tstep <= '0;
                            r_st <= S_TAN;
                        end else r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
    import cscp_pkg::*;
();

    typedef struct packed {
        logic signed [18:0] sx, sy, c1x, c1y, c2x, c2y, ex, ey;
        logic               lastseg;
    } seg_t;

    // segment predictor: keeps its own knot window and tension
    class segment_scoreboard;
        longint wx[3];
        longint wy[3];
        int     seen;
        longint tens;
        seg_t   pending[$];
        int     errors;

        function new();
            seen = 0;
            tens = longint'(TENSION_RST);
            errors = 0;
            for (int i = 0; i < 3; i++) begin
                wx[i] = 0;
                wy[i] = 0;
            end
        endfunction

        function longint clip19(longint v);
            if (v > 262143) return 262143;
            if (v < -262144) return -262144;
            return v;
        endfunction

        function longint unit_clip(longint v);
            if (v < 0) return 0;
            if (v > 65536) return 65536;
            return v;
        endfunction

        function longint fshift(longint v, int s);
            if (v >= 0) return v >>> s;
            return -((-v + (longint'(1) << s) - 1) >>> s);
        endfunction

        function longint tangent(longint d);
            return fshift(d * tens + 32768, 16);
        endfunction

        function longint ratio(longint num, longint den, longint dy);
            if (den == 0) return 0;
            return (num * dy) / den;
        endfunction

        function seg_t make_seg(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy, longint dx, longint dy,
                                bit lst);
            seg_t s;
            longint b2x, b2y, c2x, c2y, mid, nyc, nyb;
            b2x = clip19(bx + tangent(cx - ax));
            b2y = clip19(unit_clip(by + tangent(cy - ay)));
            c2x = clip19(cx + tangent(bx - dx));
            c2y = clip19(unit_clip(cy + tangent(by - dy)));
            if (b2x > cx) begin
                b2y = clip19(cy + ratio(cx - bx, b2x - bx, b2y - cy));
                b2x = cx;
            end
            if (c2x < bx) begin
                c2y = clip19(by + ratio(cx - bx, cx - c2x, c2y - by));
                c2x = bx;
            end
            if (c2x < b2x) begin
                mid = fshift(b2x + c2x, 1);
                nyc = clip19(cy + ratio(mid - cx, cx - c2x, cy - c2y));
                nyb = clip19(by + ratio(mid - bx, bx - b2x, by - b2y));
                c2y = nyc;
                b2y = nyb;
                c2x = mid;
                b2x = mid;
            end
            s.sx = 19'(bx); s.sy = 19'(by); s.c1x = 19'(b2x); s.c1y = 19'(b2y);
            s.c2x = 19'(c2x); s.c2y = 19'(c2y); s.ex = 19'(cx); s.ey = 19'(cy);
            s.lastseg = lst;
            return s;
        endfunction

        function void note_knot(longint kx, longint ky, bit lst);
            longint ax, ay;
            if (seen >= 2) begin
                if (seen == 2) begin
                    ax = 2 * wx[1] - wx[2];
                    ay = 2 * wy[1] - wy[2];
                end else begin
                    ax = wx[0];
                    ay = wy[0];
                end
                pending.insert(pending.size(),
                               make_seg(ax, ay, wx[1], wy[1], wx[2], wy[2], kx, ky, 1'b0));
                if (lst)
                    pending.insert(pending.size(),
                                   make_seg(wx[1], wy[1], wx[2], wy[2], kx, ky,
                                            2 * kx - wx[2], 2 * ky - wy[2], 1'b1));
            end
            wx[0] = wx[1]; wy[0] = wy[1];
            wx[1] = wx[2]; wy[1] = wy[2];
            wx[2] = kx; wy[2] = ky;
            if (lst) seen = 0;
            else if (seen < 3) seen++;
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_segment(seg_t got);
            seg_t e;
            if (pending.size() == 0) begin
                $error("segment transfer with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("start_x", longint'(e.sx), longint'(got.sx));
            cmp("start_y", longint'(e.sy), longint'(got.sy));
            cmp("ctrl1_x", longint'(e.c1x), longint'(got.c1x));
            cmp("ctrl1_y", longint'(e.c1y), longint'(got.c1y));
            cmp("ctrl2_x", longint'(e.c2x), longint'(got.c2x));
            cmp("ctrl2_y", longint'(e.c2y), longint'(got.c2y));
            cmp("end_x", longint'(e.ex), longint'(got.ex));
            cmp("end_y", longint'(e.ey), longint'(got.ey));
            cmp("last_segment", longint'(e.lastseg), longint'(got.lastseg));
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [15:0]  i_cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = 0;   // knot_x, knot_y
    logic         s_axis_tlast = 0;   // last_knot
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [151:0] m_axis_tdata;       // start_x/y, ctrl1_x/y, ctrl2_x/y, end_x/y
    logic         m_axis_tlast;       // last_segment

    segment_scoreboard sb = new();
    bit hold_long = 0;
    int gap_max = 3;

    curve_segment_control_points dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        seg_t g;
        if (m_axis_tvalid && m_axis_tready) begin
            g.sx = m_axis_tdata[18:0];     g.sy = m_axis_tdata[37:19];
            g.c1x = m_axis_tdata[56:38];   g.c1y = m_axis_tdata[75:57];
            g.c2x = m_axis_tdata[94:76];   g.c2y = m_axis_tdata[113:95];
            g.ex = m_axis_tdata[132:114];  g.ey = m_axis_tdata[151:133];
            g.lastseg = m_axis_tlast;
            sb.check_segment(g);
        end
        if (hold_long) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_knot(logic [16:0] kx, logic [16:0] ky, bit lst);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, ky, kx};
        s_axis_tlast <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_knot(longint'(kx), longint'(ky), lst);
        // burst-and-gap pacing
        if (gap_max > 0 && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 0;
            wait_cycles($urandom_range(1, gap_max));
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        wait_cycles(400);
    endtask

    task automatic write_tension(logic [15:0] t);
        i_cfg_we <= 1;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.tens = longint'(t);
    endtask

    function automatic logic [16:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_curve(int n, bit ordered);
        logic [16:0] x;
        x = 17'($urandom_range(0, 4000));
        for (int i = 0; i < n; i++) begin
            if (ordered) x = x + 17'($urandom_range(0, 9000));
            send_knot(ordered ? x : rnd_coord(),
                      ordered ? 17'($urandom_range(0, 65536)) : rnd_coord(), i == n - 1);
        end
    endtask

    initial begin
        logic [15:0] tset[5] = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd13107};
        wait_cycles(11);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: short curves, extremes, crossing control points
        send_knot(17'd100, 17'd200, 1);
        send_knot(17'd0, 17'd0, 0);
        send_knot(17'd65536, 17'd65536, 1);
        send_knot(17'd0, 17'd0, 0);
        send_knot(17'd30000, 17'd65536, 0);
        send_knot(17'd65536, 17'd0, 1);
        send_knot(17'd0, 17'd65536, 0);
        send_knot(17'd0, 17'd0, 0);
        send_knot(17'd0, 17'd65536, 0);
        send_knot(17'd10, 17'd5, 0);
        send_knot(17'd11, 17'd65536, 1);
        send_knot(17'h1FFFF, 17'h1FFFF, 0);
        send_knot(17'd0, 17'd0, 0);
        send_knot(17'h1FFFF, 17'h1FFFF, 0);
        send_knot(17'd0, 17'h1FFFF, 1);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            write_tension(tset[ph]);
            for (int k = 0; k < 52; k++) begin
                if ($urandom_range(0, 9) == 0) random_curve($urandom_range(1, 6), 0);
                else random_curve($urandom_range(2, 9), 1);
                if (k == 20) gap_max = 0;
                if (k == 30) gap_max = 12;
            end
            if (ph == 2) begin
                // long receiver hold-off while knots keep coming
                fork
                    begin
                        hold_long = 1;
                        wait_cycles(3000);
                        hold_long = 0;
                    end
                    random_curve(12, 1);
                join
            end
            gap_max = 3;
            drain();
        end
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/cscp_pkg.sv
rtl/cscp_div.sv
rtl/curve_segment_control_points.sv
test/tb_top.sv
